>>> rtl/assert_macros.svh
// Assertion macros for the checker file of the glyph mapper.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ULGM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ulgm check failed");

// Next-cycle implication, held off during reset.
`define ULGM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ulgm check failed");

`endif

>>> rtl/ulgm_pkg.sv
// Shared types, codes, glyph ROM and cursor helpers of the glyph mapper.
// Used by every RTL module of the block; depends on nothing.
`default_nettype none

package ulgm_pkg;

  localparam int MAX_SLOTS = 8;
  localparam int SLOT_W    = 3;
  localparam int ROM_LEN   = 15;
  localparam int ROM_IW    = 4;

  // input actions
  localparam logic [2:0] ACT_TEXT   = 3'd0;
  localparam logic [2:0] ACT_END    = 3'd1;
  localparam logic [2:0] ACT_NEWLN  = 3'd2;
  localparam logic [2:0] ACT_SETCUR = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;
  localparam logic [2:0] ACT_HOME   = 3'd5;
  localparam logic [2:0] ACT_MAPRST = 3'd6;

  // result kinds
  localparam logic [2:0] KIND_GLYPH  = 3'd0;
  localparam logic [2:0] KIND_WRITE  = 3'd1;
  localparam logic [2:0] KIND_CLEAR  = 3'd2;
  localparam logic [2:0] KIND_HOME   = 3'd3;
  localparam logic [2:0] KIND_SETCUR = 3'd4;

  // register indexes
  localparam logic [1:0] CFG_COLUMNS  = 2'd0;
  localparam logic [1:0] CFG_ROWS     = 2'd1;
  localparam logic [1:0] CFG_RESERVED = 2'd2;

  localparam logic [7:0] LEAD_C2 = 8'hC2;
  localparam logic [7:0] LEAD_C3 = 8'hC3;

  localparam logic [7:0] ROM_LEAD [ROM_LEN] = '{
    8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC2, 8'hC2,
    8'hC2, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'hC3
  };

  localparam logic [7:0] ROM_TRAIL [ROM_LEN] = '{
    8'hA1, 8'hA9, 8'hAD, 8'hB3, 8'hBA, 8'hB1, 8'hB0, 8'hA1,
    8'hBF, 8'h81, 8'h89, 8'h8D, 8'h93, 8'h9A, 8'h91
  };

  localparam logic [7:0] ROM_FALLBACK [ROM_LEN] = '{
    8'h61, 8'h65, 8'h69, 8'h6F, 8'h75, 8'h6E, 8'h6F, 8'h21,
    8'h3F, 8'h61, 8'h65, 8'h69, 8'h6F, 8'h75, 8'h6E
  };

  // pixel rows, top row first
  localparam logic [4:0] ROM_ROWS [ROM_LEN][8] = '{
    '{5'h01, 5'h02, 5'h0E, 5'h01, 5'h0E, 5'h11, 5'h0E, 5'h00},
    '{5'h01, 5'h02, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E, 5'h00},
    '{5'h02, 5'h04, 5'h00, 5'h0C, 5'h04, 5'h04, 5'h0E, 5'h00},
    '{5'h01, 5'h02, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00},
    '{5'h02, 5'h04, 5'h11, 5'h11, 5'h11, 5'h13, 5'h0D, 5'h00},
    '{5'h0E, 5'h00, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11, 5'h00},
    '{5'h0C, 5'h12, 5'h0C, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
    '{5'h04, 5'h00, 5'h00, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00},
    '{5'h04, 5'h00, 5'h04, 5'h08, 5'h10, 5'h11, 5'h0E, 5'h00},
    '{5'h04, 5'h0A, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h0F, 5'h00},
    '{5'h04, 5'h0A, 5'h1F, 5'h10, 5'h1E, 5'h10, 5'h1F, 5'h00},
    '{5'h08, 5'h10, 5'h0E, 5'h04, 5'h04, 5'h04, 5'h0E, 5'h00},
    '{5'h04, 5'h0A, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00},
    '{5'h04, 5'h0A, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00},
    '{5'h0E, 5'h00, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h00}
  };

  typedef struct packed {
    logic              hit;
    logic [ROM_IW-1:0] idx;
  } rom_hit_t;

  typedef struct packed {
    logic [5:0] col;
    logic [2:0] row;
  } cur_t;

  typedef struct packed {
    cur_t pos;
    cur_t nxt;
  } cur_wr_t;

  typedef struct packed {
    logic              assign_en;
    logic              clear_all;
    logic              res_we;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        res_value;
  } alloc_cmd_t;

  typedef struct packed {
    logic              any_free;
    logic [SLOT_W-1:0] low_slot;
    logic [3:0]        free_cnt;
  } alloc_stat_t;

  // layout of m_tdata, lowest field last
  typedef struct packed {
    logic              pad;
    logic [3:0]        free_slots;
    logic [4:0]        glyph_bits;
    logic [2:0]        glyph_line;
    logic [SLOT_W-1:0] glyph_slot;
    logic [7:0]        char_code;
    logic [1:0]        pos_row;
    logic [5:0]        pos_col;
  } out_word_t;

  function automatic rom_hit_t rom_find(input logic [7:0] lead, input logic [7:0] trail);
    rom_hit_t r;
    r = '0;
    for (int i = ROM_LEN - 1; i >= 0; i--) begin
      if (ROM_LEAD[i] == lead && ROM_TRAIL[i] == trail) begin
        r.hit = 1'b1;
        r.idx = ROM_IW'(i);
      end
    end
    return r;
  endfunction

  function automatic cur_t line_end(input cur_t c, input logic [3:0] rused);
    cur_t       r;
    logic [3:0] row4;
    row4 = {1'b0, c.row} + 4'd1;
    if (row4 >= rused) row4 = rused - 4'd1;
    r.col = '0;
    r.row = row4[2:0];
    return r;
  endfunction

  // position of a character write and the cursor after it
  function automatic cur_wr_t cursor_write(input cur_t c, input logic [6:0] cused,
                                           input logic [3:0] rused);
    cur_wr_t    w;
    cur_t       p;
    logic [6:0] nc;
    p = c;
    if ({1'b0, p.col} >= cused) p = line_end(p, rused);
    if ({1'b0, p.row} >= rused) p.row = 3'(rused - 4'd1);
    w.pos = p;
    nc = {1'b0, p.col} + 7'd1;
    if (nc >= cused) begin
      w.nxt = line_end(p, rused);
    end else begin
      w.nxt.col = nc[5:0];
      w.nxt.row = p.row;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ulgm_slot_mem.sv
// Slot-of-character memory: one write port, one registered read port.
// Uses ulgm_pkg for the slot width.
`default_nettype none

module ulgm_slot_mem #(
  parameter int DEPTH = 15,
  parameter int AW    = 4
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [ulgm_pkg::SLOT_W-1:0]   wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [ulgm_pkg::SLOT_W-1:0]   rdata
);
  import ulgm_pkg::*;

  logic [SLOT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/ulgm_alloc.sv
// Glyph slot bookkeeping: reserved mask, occupancy, owner of each slot.
// Qualifies slot memory entries and finds the lowest free slot; uses ulgm_pkg.
`default_nettype none

module ulgm_alloc #(
  parameter int NUM_SLOTS = 8,
  parameter int IDX_W     = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ulgm_pkg::alloc_cmd_t          cmd,
  input  logic [IDX_W-1:0]              idx,
  input  logic [ulgm_pkg::SLOT_W-1:0]   q_slot,
  output logic                          owned,
  output ulgm_pkg::alloc_stat_t         stat
);
  import ulgm_pkg::*;

  localparam logic [MAX_SLOTS-1:0] SLOT_MASK = MAX_SLOTS'((1 << NUM_SLOTS) - 1);

  logic [MAX_SLOTS-1:0] reserved;
  logic [MAX_SLOTS-1:0] used;
  logic [MAX_SLOTS-1:0] used_next;
  logic [MAX_SLOTS-1:0] free_mask;
  logic [IDX_W-1:0]     owner [MAX_SLOTS];

  always_comb begin
    used_next = used;
    if (cmd.clear_all) used_next = '0;
    // drop mappings that land on a newly reserved slot
    if (cmd.res_we) used_next = used_next & ~(cmd.res_value & ~reserved);
    if (cmd.assign_en) used_next[cmd.slot] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
      used     <= '0;
    end else begin
      used <= used_next;
      if (cmd.res_we) reserved <= cmd.res_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.assign_en) owner[cmd.slot] <= idx;
  end

  assign free_mask = SLOT_MASK & ~reserved & ~used;

  always_comb begin
    stat = '0;
    for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
      if (free_mask[s]) begin
        stat.any_free = 1'b1;
        stat.low_slot = SLOT_W'(s);
      end
    end
    for (int s = 0; s < MAX_SLOTS; s++) begin
      stat.free_cnt = stat.free_cnt + {3'b000, free_mask[s]};
    end
  end

  assign owned = used[q_slot] && SLOT_MASK[q_slot] && (owner[q_slot] == idx);

endmodule

`default_nettype wire

>>> rtl/utf8_accent_lcd_glyph_mapper.sv
// Top level of the UTF-8 accent to character-LCD glyph mapper.
// Uses ulgm_pkg, ulgm_slot_mem and ulgm_alloc.
//
//   Channel  Direction  Signals                                   One word is
//   s        in         s_tvalid s_tready s_tdata                 one text byte or command
//   m        out        m_tvalid m_tready m_tdata m_tuser m_tlast one LCD command
//   cfg      in         cfg_we cfg_index cfg_data                 one register write
//
// A plain byte goes through accept, decode and write (idle, main and char states);
// a held lead byte written out first adds the flush state, and a first-seen accented
// character adds its glyph rows; the sequencer gives one word per cycle unless m stalls.
// The slot memory is read in the accept cycle and its data is used in the decode state.
// Reset sets 16 columns and 2 rows and clears cursor, held byte, reserved mask and slot
// occupancy; no clearing pass, as the occupancy table qualifies every slot memory entry.
// A stall on m holds the sequencer; s_tready is high only while the sequencer is idle.
`default_nettype none

module utf8_accent_lcd_glyph_mapper #(
  parameter int NUM_SPECIALS = 15,
  parameter int NUM_SLOTS    = 8,
  parameter int MAX_COLUMNS  = 40,
  parameter int MAX_ROWS     = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // action[2:0], text_byte[10:3], target_col[16:11],
                                 // target_row[19:17], zero[23:20]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pos_col[5:0], pos_row[7:6], char_code[15:8],
                                 // glyph_slot[18:16], glyph_line[21:19],
                                 // glyph_bits[26:22], free_slots[30:27], zero[31]
  output logic [2:0]  m_tuser,   // kind[2:0]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import ulgm_pkg::*;

  localparam int IDX_W = (NUM_SPECIALS > 1) ? $clog2(NUM_SPECIALS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FLUSH = 3'd1;
  localparam logic [2:0] ST_MAIN  = 3'd2;
  localparam logic [2:0] ST_GLYPH = 3'd3;
  localparam logic [2:0] ST_CHAR  = 3'd4;
  localparam logic [2:0] ST_CMD   = 3'd5;

  logic [2:0]        state;
  logic [5:0]        columns;
  logic [2:0]        rows;
  logic              held_valid;
  logic [7:0]        held_byte;
  cur_t              cur;
  logic [2:0]        act;
  logic [7:0]        byt;
  logic [5:0]        tcol;
  logic [2:0]        trow;
  logic              hit;
  logic [ROM_IW-1:0] ridx;
  logic [7:0]        code;
  logic [SLOT_W-1:0] gslot;
  logic [2:0]        gline;

  logic [2:0]        in_action;
  logic [7:0]        in_byte;
  logic [6:0]        cused;
  logic [3:0]        rused;
  rom_hit_t          fnd;
  logic              in_hit;
  logic              in_flush;
  logic              s_accept;
  logic              out_free;
  logic              byt_lead;
  logic              more;
  cur_wr_t           wr;
  cur_t              setc;
  logic [IDX_W-1:0]  midx;
  logic [SLOT_W-1:0] mem_rdata;
  logic              owned;
  alloc_cmd_t        cmd;
  alloc_stat_t       stat;
  logic              emit;
  out_word_t         eword;
  logic [2:0]        ekind;
  logic              elast;

  assign in_action = s_tdata[2:0];
  assign in_byte   = s_tdata[10:3];

  assign cused = (columns == 6'd0) ? 7'd1 :
                 ({1'b0, columns} > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : {1'b0, columns};
  assign rused = (rows == 3'd0) ? 4'd1 :
                 ({1'b0, rows} > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : {1'b0, rows};

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign fnd      = rom_find(held_byte, in_byte);
  assign in_hit   = held_valid && (in_action == ACT_TEXT) && fnd.hit &&
                    (int'(fnd.idx) < NUM_SPECIALS);
  assign in_flush = held_valid && !in_hit && (in_action <= ACT_MAPRST);

  assign midx     = IDX_W'(ridx);
  assign byt_lead = (byt == LEAD_C2) || (byt == LEAD_C3);
  assign more     = ((act == ACT_TEXT) && !byt_lead) ||
                    (act inside {ACT_SETCUR, ACT_CLEAR, ACT_HOME});

  assign wr = cursor_write(cur, cused, rused);

  always_comb begin
    setc.col = ({1'b0, tcol} < cused) ? tcol : 6'(cused - 7'd1);
    setc.row = ({1'b0, trow} < rused) ? trow : 3'(rused - 4'd1);
  end

  // slot allocation and map commands
  always_comb begin
    cmd           = '0;
    cmd.slot      = stat.low_slot;
    cmd.res_value = cfg_data;
    cmd.res_we    = cfg_we && (cfg_index == CFG_RESERVED);
    cmd.assign_en = (state == ST_MAIN) && (act == ACT_TEXT) && hit && !owned &&
                    stat.any_free;
    cmd.clear_all = (state == ST_MAIN) && (act == ACT_MAPRST);
  end

  ulgm_slot_mem #(
    .DEPTH (NUM_SPECIALS),
    .AW    (IDX_W)
  ) u_slot_mem (
    .clk   (clk),
    .we    (cmd.assign_en),
    .waddr (midx),
    .wdata (stat.low_slot),
    .re    (s_accept),
    .raddr (IDX_W'(fnd.idx)),
    .rdata (mem_rdata)
  );

  ulgm_alloc #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_alloc (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .idx    (midx),
    .q_slot (mem_rdata),
    .owned  (owned),
    .stat   (stat)
  );

  // word for the output register
  always_comb begin
    eword            = '0;
    eword.free_slots = stat.free_cnt;
    ekind            = KIND_WRITE;
    elast            = 1'b1;
    emit             = out_free && (state inside {ST_FLUSH, ST_GLYPH, ST_CHAR, ST_CMD});
    case (state)
      ST_FLUSH: begin
        eword.pos_col   = wr.pos.col;
        eword.pos_row   = wr.pos.row[1:0];
        eword.char_code = held_byte;
        elast           = !more;
      end
      ST_CHAR: begin
        eword.pos_col   = wr.pos.col;
        eword.pos_row   = wr.pos.row[1:0];
        eword.char_code = code;
      end
      ST_GLYPH: begin
        ekind            = KIND_GLYPH;
        eword.glyph_slot = gslot;
        eword.glyph_line = gline;
        eword.glyph_bits = ROM_ROWS[ridx][gline];
        elast            = 1'b0;
      end
      ST_CMD: begin
        case (act)
          ACT_SETCUR: begin
            ekind         = KIND_SETCUR;
            eword.pos_col = setc.col;
            eword.pos_row = setc.row[1:0];
          end
          ACT_CLEAR: ekind = KIND_CLEAR;
          default:   ekind = KIND_HOME;
        endcase
      end
      default: begin
        elast = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      columns    <= 6'd16;
      rows       <= 3'd2;
      held_valid <= 1'b0;
      held_byte  <= 8'd0;
      cur        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_COLUMNS) columns <= cfg_data[5:0];
      if (cfg_we && cfg_index == CFG_ROWS) rows <= cfg_data[2:0];

      if (out_free) begin
        m_tvalid <= emit;
        if (emit) begin
          m_tdata <= eword;
          m_tuser <= ekind;
          m_tlast <= elast;
        end
      end

      case (state)
        ST_IDLE: begin
          if (s_accept && in_action <= ACT_MAPRST) begin
            act   <= in_action;
            byt   <= in_byte;
            tcol  <= s_tdata[16:11];
            trow  <= s_tdata[19:17];
            hit   <= in_hit;
            ridx  <= fnd.idx;
            state <= in_flush ? ST_FLUSH : ST_MAIN;
          end
        end
        ST_FLUSH: begin
          if (emit) begin
            cur        <= wr.nxt;
            held_valid <= 1'b0;
            state      <= ST_MAIN;
          end
        end
        ST_MAIN: begin
          state <= ST_IDLE;
          case (act)
            ACT_TEXT: begin
              if (hit) begin
                held_valid <= 1'b0;
                gline      <= 3'd0;
                gslot      <= stat.low_slot;
                if (owned) begin
                  code  <= {{(8 - SLOT_W){1'b0}}, mem_rdata};
                  state <= ST_CHAR;
                end else if (stat.any_free) begin
                  code  <= {{(8 - SLOT_W){1'b0}}, stat.low_slot};
                  state <= ST_GLYPH;
                end else begin
                  code  <= ROM_FALLBACK[ridx];
                  state <= ST_CHAR;
                end
              end else if (byt_lead) begin
                held_valid <= 1'b1;
                held_byte  <= byt;
              end else begin
                code  <= byt;
                state <= ST_CHAR;
              end
            end
            ACT_NEWLN: cur <= line_end(cur, rused);
            ACT_SETCUR, ACT_CLEAR, ACT_HOME: state <= ST_CMD;
            default: state <= ST_IDLE;
          endcase
        end
        ST_GLYPH: begin
          if (emit) begin
            gline <= gline + 3'd1;
            if (gline == 3'd7) state <= ST_CHAR;
          end
        end
        ST_CHAR: begin
          if (emit) begin
            cur   <= wr.nxt;
            state <= ST_IDLE;
          end
        end
        ST_CMD: begin
          if (emit) begin
            cur   <= (act == ACT_SETCUR) ? setc : '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/ulgm_checker.sv
// Port-level checks of the glyph mapper, bound to the top level.
// Uses ulgm_pkg and the macros of assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ulgm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [2:0]  m_tuser,
  input wire logic        m_tlast
);
  import ulgm_pkg::*;

  logic glyph_taken;

  assign glyph_taken = m_tvalid && m_tready && (m_tuser == KIND_GLYPH);

  // a stalled word holds
  `ULGM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // a glyph row never ends an item and carries no position or code
  `ULGM_ASSERT_NOW(a_glyph_shape, m_tvalid && m_tuser == KIND_GLYPH, !m_tlast && m_tdata[15:0] == 16'd0)

  // glyph rows of one slot follow each other in line order
  `ULGM_ASSERT_NEXT(a_glyph_seq, glyph_taken && m_tdata[21:19] != 3'd7, m_tvalid && m_tuser == KIND_GLYPH && m_tdata[21:19] == $past(m_tdata[21:19]) + 3'd1 && m_tdata[18:16] == $past(m_tdata[18:16]))

  // the last glyph row is followed by a write of that slot
  `ULGM_ASSERT_NEXT(a_glyph_use, glyph_taken && m_tdata[21:19] == 3'd7, m_tvalid && m_tuser == KIND_WRITE && m_tdata[15:8] == 8'($past(m_tdata[18:16])))

  // no new word is taken while an item still has results to give
  `ULGM_ASSERT_NOW(a_item_busy, m_tvalid && !m_tlast, !s_tready)

endmodule

bind utf8_accent_lcd_glyph_mapper ulgm_checker u_ulgm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

>>> tb/tb_utf8_accent_lcd_glyph_mapper.sv
// Self-checking testbench for utf8_accent_lcd_glyph_mapper: text bytes and commands in,
// LCD command words out, checked against an in-bench model of cursor and glyph slots.
// Depends on ulgm_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_utf8_accent_lcd_glyph_mapper;
  import ulgm_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 16;
  localparam int NO_SLOT = 8;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] col;
    logic [1:0] row;
    logic [7:0] code;
    logic [2:0] slot;
    logic [2:0] gline;
    logic [4:0] pix;
    logic [3:0] free;
    logic       last;
  } lcd_cmd_t;

  // lead, trail, ASCII fallback, then pixel rows top first
  function automatic logic [63:0] accent_glyph(int idx);
    case (idx)
      0:  return {8'hC3, 8'hA1, 8'h61, 5'h01, 5'h02, 5'h0E, 5'h01, 5'h0E, 5'h11, 5'h0E, 5'h00};
      1:  return {8'hC3, 8'hA9, 8'h65, 5'h01, 5'h02, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E, 5'h00};
      2:  return {8'hC3, 8'hAD, 8'h69, 5'h02, 5'h04, 5'h00, 5'h0C, 5'h04, 5'h04, 5'h0E, 5'h00};
      3:  return {8'hC3, 8'hB3, 8'h6F, 5'h01, 5'h02, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00};
      4:  return {8'hC3, 8'hBA, 8'h75, 5'h02, 5'h04, 5'h11, 5'h11, 5'h11, 5'h13, 5'h0D, 5'h00};
      5:  return {8'hC3, 8'hB1, 8'h6E, 5'h0E, 5'h00, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11, 5'h00};
      6:  return {8'hC2, 8'hB0, 8'h6F, 5'h0C, 5'h12, 5'h0C, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      7:  return {8'hC2, 8'hA1, 8'h21, 5'h04, 5'h00, 5'h00, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00};
      8:  return {8'hC2, 8'hBF, 8'h3F, 5'h04, 5'h00, 5'h04, 5'h08, 5'h10, 5'h11, 5'h0E, 5'h00};
      9:  return {8'hC3, 8'h81, 8'h61, 5'h04, 5'h0A, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h0F, 5'h00};
      10: return {8'hC3, 8'h89, 8'h65, 5'h04, 5'h0A, 5'h1F, 5'h10, 5'h1E, 5'h10, 5'h1F, 5'h00};
      11: return {8'hC3, 8'h8D, 8'h69, 5'h08, 5'h10, 5'h0E, 5'h04, 5'h04, 5'h04, 5'h0E, 5'h00};
      12: return {8'hC3, 8'h93, 8'h6F, 5'h04, 5'h0A, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00};
      13: return {8'hC3, 8'h9A, 8'h75, 5'h04, 5'h0A, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00};
      default:
          return {8'hC3, 8'h91, 8'h6E, 5'h0E, 5'h00, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h00};
    endcase
  endfunction

  class lcd_cmd_tracker;
    int unsigned columns, rows, reserved;
    bit          held_valid;
    int unsigned held_byte;
    int unsigned cur_col, cur_row;
    int unsigned slot_of[15];
    lcd_cmd_t    pending_cmds[$];
    lcd_cmd_t    step_cmds[$];
    int          errors;

    function new();
      columns = 16;
      rows = 2;
      reserved = 0;
      held_valid = 0;
      held_byte = 0;
      cur_col = 0;
      cur_row = 0;
      errors = 0;
      foreach (slot_of[i]) slot_of[i] = NO_SLOT;
    endfunction

    function int unsigned cols_used();
      if (columns < 1) return 1;
      if (columns > 40) return 40;
      return columns;
    endfunction

    function int unsigned rows_used();
      if (rows < 1) return 1;
      if (rows > 4) return 4;
      return rows;
    endfunction

    function bit slot_taken(int unsigned s);
      foreach (slot_of[i]) if (slot_of[i] == s) return 1;
      return 0;
    endfunction

    function int unsigned free_count();
      int unsigned n;
      n = 0;
      for (int s = 0; s < 8; s++) if (!reserved[s] && !slot_taken(s)) n++;
      return n;
    endfunction

    function void emit(logic [2:0] kind, int unsigned col, int unsigned row,
                       int unsigned code, int unsigned slot, int unsigned gline,
                       int unsigned pix);
      lcd_cmd_t c;
      c.kind = kind;
      c.col = col[5:0];
      c.row = row[1:0];
      c.code = code[7:0];
      c.slot = slot[2:0];
      c.gline = gline[2:0];
      c.pix = pix[4:0];
      c.free = free_count();
      c.last = 1'b0;
      step_cmds.push_back(c);
    endfunction

    function void next_line();
      cur_row++;
      cur_col = 0;
      if (cur_row >= rows_used()) cur_row = rows_used() - 1;
    endfunction

    function void put_char(int unsigned code);
      // a cursor left outside a shrunk display is pulled back in first
      if (cur_col >= cols_used()) next_line();
      if (cur_row >= rows_used()) cur_row = rows_used() - 1;
      emit(KIND_WRITE, cur_col, cur_row, code, 0, 0, 0);
      cur_col++;
      if (cur_col >= cols_used()) next_line();
    endfunction

    function void flush_lead();
      if (held_valid) begin
        held_valid = 0;
        put_char(held_byte);
      end
    endfunction

    function void plain_byte(int unsigned b);
      if (b == LEAD_C2 || b == LEAD_C3) begin
        held_valid = 1;
        held_byte = b;
      end else begin
        put_char(b);
      end
    endfunction

    function void text_in(int unsigned b);
      int          idx;
      logic [63:0] e;
      idx = -1;
      if (!held_valid) begin
        plain_byte(b);
        return;
      end
      for (int i = 14; i >= 0; i--) begin
        e = accent_glyph(i);
        if (e[63:56] == held_byte && e[55:48] == b) idx = i;
      end
      if (idx < 0) begin
        flush_lead();
        plain_byte(b);
        return;
      end
      held_valid = 0;
      e = accent_glyph(idx);
      if (slot_of[idx] == NO_SLOT) begin
        for (int s = 0; s < 8; s++) begin
          if (!reserved[s] && !slot_taken(s)) begin
            slot_of[idx] = s;
            for (int l = 0; l < 8; l++) emit(KIND_GLYPH, 0, 0, 0, s, l, e[39-5*l -: 5]);
            break;
          end
        end
      end
      if (slot_of[idx] != NO_SLOT) put_char(slot_of[idx]);
      else put_char(e[47:40]);
    endfunction

    function void take_word(logic [2:0] action, logic [7:0] b, logic [5:0] tc, logic [2:0] tr);
      step_cmds.delete();
      if (action == 3'd7) return;
      if (action == ACT_TEXT) begin
        text_in(b);
      end else begin
        flush_lead();
        case (action)
          ACT_NEWLN: next_line();
          ACT_SETCUR: begin
            cur_col = (tc < cols_used()) ? tc : cols_used() - 1;
            cur_row = (tr < rows_used()) ? tr : rows_used() - 1;
            emit(KIND_SETCUR, cur_col, cur_row, 0, 0, 0, 0);
          end
          ACT_CLEAR: begin
            cur_col = 0;
            cur_row = 0;
            emit(KIND_CLEAR, 0, 0, 0, 0, 0, 0);
          end
          ACT_HOME: begin
            cur_col = 0;
            cur_row = 0;
            emit(KIND_HOME, 0, 0, 0, 0, 0, 0);
          end
          ACT_MAPRST: foreach (slot_of[i]) slot_of[i] = NO_SLOT;
          default: ;
        endcase
      end
      if (step_cmds.size() > 0) step_cmds[step_cmds.size()-1].last = 1'b1;
      foreach (step_cmds[i]) pending_cmds.push_back(step_cmds[i]);
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] value);
      logic [7:0] newly;
      case (idx)
        CFG_COLUMNS: columns = value[5:0];
        CFG_ROWS:    rows = value[2:0];
        CFG_RESERVED: begin
          // drop every mapping that sits on a slot reserved just now
          newly = value & ~reserved[7:0];
          reserved = value;
          foreach (slot_of[i])
            if (slot_of[i] < 8 && newly[slot_of[i]]) slot_of[i] = NO_SLOT;
        end
        default: ;
      endcase
    endfunction

    function void field_eq(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_cmd(lcd_cmd_t got);
      lcd_cmd_t exp_c;
      if (pending_cmds.size() == 0) begin
        $error("unexpected command word: kind %0d code %0d", got.kind, got.code);
        errors++;
        return;
      end
      exp_c = pending_cmds.pop_front();
      field_eq("kind", exp_c.kind, got.kind);
      field_eq("pos_col", exp_c.col, got.col);
      field_eq("pos_row", exp_c.row, got.row);
      field_eq("char_code", exp_c.code, got.code);
      field_eq("glyph_slot", exp_c.slot, got.slot);
      field_eq("glyph_line", exp_c.gline, got.gline);
      field_eq("glyph_bits", exp_c.pix, got.pix);
      field_eq("free_slots", exp_c.free, got.free);
      field_eq("last", exp_c.last, got.last);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // action[2:0], text_byte[10:3], target_col[16:11], target_row[19:17]
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // pos_col, pos_row, char_code, glyph_slot, glyph_line,
                          // glyph_bits, free_slots
  logic [2:0]  m_tuser;   // kind
  logic        m_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  lcd_cmd_tracker sb;
  int send_idle;
  int recv_idle;
  int cycle_count;

  int seg_cols[9] = '{1, 40, 0, 63, 5, 20, 2, 40, 16};
  int seg_rows[9] = '{1, 4, 0, 7, 3, 4, 2, 1, 2};
  int seg_resv[9] = '{0, 8'h0F, 8'hFF, 0, 8'hAA, 8'h81, 0, 8'h7E, 0};

  utf8_accent_lcd_glyph_mapper dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // check every accepted command word and pick the next ready level
  always @(posedge clk) begin
    lcd_cmd_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.col = m_tdata[5:0];
        got.row = m_tdata[7:6];
        got.code = m_tdata[15:8];
        got.slot = m_tdata[18:16];
        got.gline = m_tdata[21:19];
        got.pix = m_tdata[26:22];
        got.free = m_tdata[30:27];
        got.last = m_tlast;
        sb.check_cmd(got);
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_word(logic [2:0] action, logic [7:0] b, logic [5:0] tc, logic [2:0] tr);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, tr, tc, b, action};
    do @(posedge clk); while (!s_tready);
    sb.take_word(action, b, tc, tr);
  endtask

  task automatic send_text(logic [7:0] b);
    send_word(ACT_TEXT, b, 6'($urandom), 3'($urandom));
  endtask

  task automatic send_cmd(logic [2:0] action);
    send_word(action, 8'($urandom), 6'($urandom), 3'($urandom));
  endtask

  // hold the sender until every command word is out and the sequencer is done
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(int cols, int nrows, int resv);
    logic [7:0] vals[3];
    logic [1:0] idxs[3];
    vals[0] = 8'(cols) | 8'($urandom_range(3) << 6);
    vals[1] = 8'(nrows) | 8'($urandom_range(31) << 3);
    vals[2] = 8'(resv);
    idxs[0] = CFG_COLUMNS;
    idxs[1] = CFG_ROWS;
    idxs[2] = CFG_RESERVED;
    cfg_we <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] any_lead();
    return $urandom_range(1) ? LEAD_C3 : LEAD_C2;
  endfunction

  // mostly well-formed accented pairs and text, with broken pairs and commands mixed in
  task automatic run_text(int n_words);
    int          sent;
    int          r;
    logic [63:0] e;
    sent = 0;
    while (sent < n_words) begin
      r = $urandom_range(99);
      if (r < 35) begin
        e = accent_glyph($urandom_range(14));
        send_text(e[63:56]);
        send_text(e[55:48]);
        sent += 2;
      end else if (r < 55) begin
        send_text(8'($urandom_range(255)));
        sent++;
      end else if (r < 63) begin
        send_text(8'($urandom_range(8'h7E, 8'h20)));
        sent++;
      end else if (r < 70) begin
        send_text(any_lead());
        send_text(8'($urandom_range(255)));
        sent += 2;
      end else if (r < 76) begin
        send_cmd(ACT_SETCUR);
        sent++;
      end else if (r < 80) begin
        send_cmd(ACT_NEWLN);
        sent++;
      end else if (r < 83) begin
        send_cmd(ACT_CLEAR);
        sent++;
      end else if (r < 86) begin
        send_cmd(ACT_HOME);
        sent++;
      end else if (r < 89) begin
        send_cmd(ACT_MAPRST);
        sent++;
      end else if (r < 92) begin
        send_cmd(ACT_END);
        sent++;
      end else if (r < 95) begin
        send_cmd(3'd7);
      end else begin
        send_text(any_lead());
        send_cmd(3'($urandom_range(6, 1)));
        sent += 2;
      end
    end
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    send_idle = 6;
    recv_idle = 76;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: byte extremes, glyph upload and reuse, broken pairs, every command
    send_text(8'h41);
    send_text(8'h00);
    send_text(8'hFF);
    send_text(LEAD_C3);
    send_text(8'hA1);
    send_text(LEAD_C3);
    send_text(8'hA1);
    send_text(LEAD_C2);
    send_text(8'hB0);
    send_text(LEAD_C3);
    send_text(8'h78);
    send_text(LEAD_C3);
    send_text(LEAD_C2);
    send_text(8'hBF);
    send_text(LEAD_C2);
    send_cmd(ACT_END);
    send_word(ACT_SETCUR, 8'h00, 6'd63, 3'd7);
    send_cmd(ACT_NEWLN);
    send_cmd(ACT_CLEAR);
    send_cmd(ACT_HOME);
    send_text(LEAD_C3);
    send_cmd(ACT_NEWLN);
    send_cmd(ACT_MAPRST);
    send_cmd(3'd7);

    seg_resv[8] = $urandom_range(255);
    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 6 : (p == 1) ? 76 : 0;
      recv_idle = (p == 0) ? 76 : (p == 1) ? 6 : 0;
      for (int k = 0; k < 3; k++) begin
        wait_drained();
        apply_settings(seg_cols[3*p+k], seg_rows[3*p+k], seg_resv[3*p+k]);
        run_text(26);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
